// ===== src/ipv4_fwd_pkg.sv =====
// Shared types and constants for the IPv4 forwarding header engine.
// No dependencies.
package ipv4_fwd_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

   // Item opcodes
   localparam logic OP_ROUTE_WRITE = 1'b0;
   localparam logic OP_HEADER_WORD = 1'b1;

   // Result status codes
   localparam logic [1:0] STATUS_FORWARD  = 2'd0;
   localparam logic [1:0] STATUS_LOCAL    = 2'd1;
   localparam logic [1:0] STATUS_NO_ROUTE = 2'd2;

   // Header word positions
   localparam logic [4:0] WORD_TTL    = 5'd4;
   localparam logic [4:0] WORD_CSUM   = 5'd5;
   localparam logic [4:0] WORD_DST_HI = 5'd8;
   localparam logic [4:0] WORD_DST_LO = 5'd9;
   localparam logic [4:0] COUNT_MAX   = 5'd31;

   localparam logic [15:0] TTL_DEC   = 16'h0100;
   localparam logic [15:0] ONES_MASK = 16'hffff;

   typedef struct packed {
      logic [31:0] gateway;
      logic [31:0] mask;
      logic [31:0] net;
      logic [7:0]  iface;
   } route_entry_type;

endpackage

// ===== src/ipv4_forward_header_engine_core.sv =====
// IPv4 forwarding header engine: route table memory, header checksum update, route walk.
// Depends on ipv4_fwd_pkg.
//
// Route writes and non-final header words are accepted back to back. The final
// header word starts a walk of the route table, which lives in a memory with one
// write port and a registered read port: one entry is read per cycle, and the walk
// reads the valid entries up to the first invalid one, at most ROUTE_ENTRIES of
// them. The input is stalled during the walk and until its result is loaded.
// The result sits in an output register, so new route writes and header words are
// taken while it waits for its transfer; a finished walk waits only if the
// previous result is still held. The valid bits are flip-flops cleared by reset;
// no clearing pass is needed.
module ipv4_forward_header_engine_core #(
   parameter int ROUTE_ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [3:0]  req_entry_index,
   input  logic [31:0] req_iface_addr,
   input  logic [31:0] req_iface_mask,
   input  logic [7:0]  req_iface_id,
   input  logic [15:0] req_header_word,
   input  logic        req_last_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_ttl_was_zero,
   output logic [7:0]  rsp_new_ttl,
   output logic [15:0] rsp_new_checksum,
   output logic [7:0]  rsp_out_iface,
   output logic [31:0] rsp_dest_addr
);

   localparam int AW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
   localparam int CW = $clog2(ROUTE_ENTRIES + 1);
   localparam logic [CW-1:0] NUM_ENT = CW'(ROUTE_ENTRIES);

   ipv4_fwd_pkg::route_entry_type route_mem [ROUTE_ENTRIES];
   ipv4_fwd_pkg::route_entry_type rd_entry_ff;
   ipv4_fwd_pkg::route_entry_type wr_entry;

   ipv4_fwd_pkg::state_type state_ff, state_in;

   logic [ROUTE_ENTRIES-1:0] valid_ff, valid_in;
   logic [4:0]  word_cnt_ff, word_cnt_in;
   logic [16:0] sum_ff, sum_in;
   logic [7:0]  ttl_ff, ttl_in;
   logic [31:0] dest_ff, dest_in;
   logic [15:0] csum_ff, csum_in;

   logic [CW-1:0] walk_idx_ff, walk_idx_in;
   logic          pend_ff, pend_in;
   logic          local_ff, local_in;
   logic          found_ff, found_in;
   logic [7:0]    iface_ff, iface_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  status_ff, status_in;
   logic        zero_ff, zero_in;
   logic [7:0]  new_ttl_ff, new_ttl_in;
   logic [15:0] new_csum_ff, new_csum_in;
   logic [7:0]  out_iface_ff, out_iface_in;
   logic [31:0] out_dest_ff, out_dest_in;
   logic        out_load;

   logic          req_xfer;
   logic          tbl_we;
   logic [AW-1:0] tbl_addr;
   logic          issue;
   logic          in_range;
   logic [15:0]   w_adj;
   logic [17:0]   sum_wide;
   logic [16:0]   sum_fold;

   assign req_stall = (state_ff != ipv4_fwd_pkg::ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign tbl_addr  = AW'(req_entry_index);
   assign wr_entry  = '{gateway: req_iface_addr, mask: req_iface_mask,
                        net: req_iface_addr & req_iface_mask, iface: req_iface_id};
   assign in_range  = (walk_idx_ff < NUM_ENT);
   assign issue     = (state_ff == ipv4_fwd_pkg::ST_WALK) && in_range
                      && valid_ff[walk_idx_ff[AW-1:0]];
   assign sum_fold  = 17'(sum_ff[15:0]) + 17'(sum_ff[16]);

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      word_cnt_in  = word_cnt_ff;
      sum_in       = sum_ff;
      ttl_in       = ttl_ff;
      dest_in      = dest_ff;
      csum_in      = csum_ff;
      walk_idx_in  = walk_idx_ff;
      pend_in      = 1'b0;
      local_in     = local_ff;
      found_in     = found_ff;
      iface_in     = iface_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = ipv4_fwd_pkg::STATUS_LOCAL;
      zero_in      = 1'b0;
      new_ttl_in   = ttl_ff;
      new_csum_in  = csum_ff;
      out_iface_in = '0;
      out_dest_in  = dest_ff;
      out_load     = 1'b0;
      tbl_we       = 1'b0;
      w_adj        = req_header_word;
      sum_wide     = 18'(sum_ff) + 18'(w_adj);

      unique case (state_ff)
         ipv4_fwd_pkg::ST_IDLE: begin
            if (req_xfer && req_op == ipv4_fwd_pkg::OP_ROUTE_WRITE) begin
               if (32'(req_entry_index) < ROUTE_ENTRIES) begin
                  tbl_we   = 1'b1;
                  valid_in[tbl_addr] = 1'b1;
               end
            end else if (req_xfer) begin
               if (word_cnt_ff == ipv4_fwd_pkg::WORD_TTL) begin
                  ttl_in = req_header_word[15:8];
                  if (req_header_word[15:8] != 8'd0) begin
                     w_adj = req_header_word - ipv4_fwd_pkg::TTL_DEC;
                  end
               end else if (word_cnt_ff == ipv4_fwd_pkg::WORD_CSUM) begin
                  csum_in = req_header_word;
                  w_adj   = '0;
               end else if (word_cnt_ff == ipv4_fwd_pkg::WORD_DST_HI) begin
                  dest_in[31:16] = req_header_word;
               end else if (word_cnt_ff == ipv4_fwd_pkg::WORD_DST_LO) begin
                  dest_in[15:0] = req_header_word;
               end
               // end-around carry folded after every word
               sum_wide = 18'(sum_ff) + 18'(w_adj);
               sum_in   = 17'(sum_wide[15:0]) + 17'(sum_wide[17:16]);
               if (word_cnt_ff != ipv4_fwd_pkg::COUNT_MAX) begin
                  word_cnt_in = word_cnt_ff + 5'd1;
               end
               if (req_last_word) begin
                  state_in    = ipv4_fwd_pkg::ST_WALK;
                  walk_idx_in = '0;
                  local_in    = 1'b0;
                  found_in    = 1'b0;
                  iface_in    = '0;
               end
            end
         end
         ipv4_fwd_pkg::ST_WALK: begin
            pend_in = issue;
            if (issue) begin
               walk_idx_in = walk_idx_ff + CW'(1);
            end
            // evaluate the entry read in the previous cycle
            if (pend_ff) begin
               if (rd_entry_ff.gateway == dest_ff) begin
                  local_in = 1'b1;
               end
               if (!found_ff && ((dest_ff & rd_entry_ff.mask) == rd_entry_ff.net)) begin
                  found_in = 1'b1;
                  iface_in = rd_entry_ff.iface;
               end
            end
            if (!issue && !pend_ff) begin
               state_in = ipv4_fwd_pkg::ST_DONE;
            end
         end
         ipv4_fwd_pkg::ST_DONE: begin
            if (!local_ff) begin
               zero_in = (ttl_ff == 8'd0);
               if (ttl_ff != 8'd0) begin
                  new_ttl_in  = ttl_ff - 8'd1;
                  new_csum_in = ~sum_fold[15:0] & ipv4_fwd_pkg::ONES_MASK;
               end
               status_in    = found_ff ? ipv4_fwd_pkg::STATUS_FORWARD
                                       : ipv4_fwd_pkg::STATUS_NO_ROUTE;
               out_iface_in = found_ff ? iface_ff : 8'd0;
            end
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ipv4_fwd_pkg::ST_IDLE;
               word_cnt_in  = '0;
               sum_in       = '0;
               ttl_in       = '0;
               dest_in      = '0;
               csum_in      = '0;
            end
         end
         default: begin
            state_in = ipv4_fwd_pkg::ST_IDLE;
         end
      endcase
   end

   // route table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (tbl_we) begin
         route_mem[tbl_addr] <= wr_entry;
      end
      if (issue) begin
         rd_entry_ff <= route_mem[walk_idx_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ipv4_fwd_pkg::ST_IDLE;
         valid_ff     <= '0;
         word_cnt_ff  <= '0;
         sum_ff       <= '0;
         ttl_ff       <= '0;
         dest_ff      <= '0;
         csum_ff      <= '0;
         walk_idx_ff  <= '0;
         pend_ff      <= 1'b0;
         local_ff     <= 1'b0;
         found_ff     <= 1'b0;
         iface_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         word_cnt_ff  <= word_cnt_in;
         sum_ff       <= sum_in;
         ttl_ff       <= ttl_in;
         dest_ff      <= dest_in;
         csum_ff      <= csum_in;
         walk_idx_ff  <= walk_idx_in;
         pend_ff      <= pend_in;
         local_ff     <= local_in;
         found_ff     <= found_in;
         iface_ff     <= iface_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         status_ff    <= status_in;
         zero_ff      <= zero_in;
         new_ttl_ff   <= new_ttl_in;
         new_csum_ff  <= new_csum_in;
         out_iface_ff <= out_iface_in;
         out_dest_ff  <= out_dest_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_ttl_was_zero = zero_ff;
   assign rsp_new_ttl      = new_ttl_ff;
   assign rsp_new_checksum = new_csum_ff;
   assign rsp_out_iface    = out_iface_ff;
   assign rsp_dest_addr    = out_dest_ff;

   // a new result only appears out of the walk's final state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (out_load |-> state_ff == ipv4_fwd_pkg::ST_DONE))
      else $error("result loaded outside of walk completion");

   // a pending read always comes from an issue in the walk state
   a_pend_from_walk: assert property (@(posedge clock) disable iff (reset)
      (pend_ff |-> $past(state_ff == ipv4_fwd_pkg::ST_WALK) && $past(issue)))
      else $error("table read pending without an issue");

   // a walk starts with cleared match flags
   a_walk_start_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ipv4_fwd_pkg::ST_WALK && $past(state_ff == ipv4_fwd_pkg::ST_IDLE)
       |-> !local_ff && !found_ff && !pend_ff && walk_idx_ff == '0))
      else $error("walk started with stale state");

   // a local result never carries an interface or a zero-TTL flag
   a_local_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == ipv4_fwd_pkg::STATUS_LOCAL
       |-> !zero_ff && out_iface_ff == 8'd0))
      else $error("local result with forwarding fields set");

   // packet state is cleared when a result is loaded
   a_packet_cleared: assert property (@(posedge clock) disable iff (reset)
      (out_load |=> word_cnt_ff == 5'd0 && sum_ff == 17'd0))
      else $error("packet state not cleared after result");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for ipv4_forward_header_engine_core: route writes and header
// streams go in, each forwarding verdict is checked against an in-bench forwarding model.
// Depends on ipv4_fwd_pkg and the core RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTRIES      = 16;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 40;

   typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_kind_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        zero_ttl;
      logic [7:0]  ttl;
      logic [15:0] csum;
      logic [7:0]  iface;
      logic [31:0] dest;
   } verdict_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_op = ipv4_fwd_pkg::OP_ROUTE_WRITE;
   logic [3:0]  req_entry_index = '0;
   logic [31:0] req_iface_addr = '0;
   logic [31:0] req_iface_mask = '0;
   logic [7:0]  req_iface_id = '0;
   logic [15:0] req_header_word = '0;
   logic        req_last_word = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_ttl_was_zero;
   logic [7:0]  rsp_new_ttl;
   logic [15:0] rsp_new_checksum;
   logic [7:0]  rsp_out_iface;
   logic [31:0] rsp_dest_addr;

   // forwarding model state
   logic        route_ok   [ENTRIES];
   logic [31:0] route_gw   [ENTRIES];
   logic [31:0] route_msk  [ENTRIES];
   logic [31:0] route_net  [ENTRIES];
   logic [7:0]  route_id   [ENTRIES];
   logic [4:0]  hdr_pos = '0;
   logic [31:0] hdr_sum = '0;
   logic [7:0]  hdr_ttl = '0;
   logic [31:0] hdr_dest = '0;
   logic [15:0] hdr_csum = '0;

   verdict_type pending_verdicts[$];
   verdict_type want;

   int  errors = 0;
   int  sent = 0;
   int  cycles = 0;
   int  gap_pct = 0;
   int  stall_pct = 0;
   bit  quiet = 1'b0;

   ipv4_forward_header_engine_core #(
      .ROUTE_ENTRIES(ENTRIES)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_entry_index(req_entry_index),
      .req_iface_addr(req_iface_addr),
      .req_iface_mask(req_iface_mask),
      .req_iface_id(req_iface_id),
      .req_header_word(req_header_word),
      .req_last_word(req_last_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_ttl_was_zero(rsp_ttl_was_zero),
      .rsp_new_ttl(rsp_new_ttl),
      .rsp_new_checksum(rsp_new_checksum),
      .rsp_out_iface(rsp_out_iface),
      .rsp_dest_addr(rsp_dest_addr)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Forwarding model: advances on every accepted transfer
   // ------------------------------------------------------------------
   task automatic forward_model_step(input logic op, input logic [3:0] idx,
                                     input logic [31:0] addr, input logic [31:0] mask,
                                     input logic [7:0] id, input logic [15:0] word,
                                     input logic last);
      logic [31:0] w;
      logic [31:0] s;
      verdict_type v;
      bit          is_local;
      bit          stop;
      int          i;
      if (op == ipv4_fwd_pkg::OP_ROUTE_WRITE) begin
         if (idx < ENTRIES) begin
            route_gw[idx]  = addr;
            route_msk[idx] = mask;
            route_net[idx] = addr & mask;
            route_id[idx]  = id;
            route_ok[idx]  = 1'b1;
         end
      end else begin
         w = {16'h0, word};
         if (hdr_pos == ipv4_fwd_pkg::WORD_TTL) begin
            hdr_ttl = word[15:8];
            if (hdr_ttl != 8'd0)
               w = w - {16'h0, ipv4_fwd_pkg::TTL_DEC};
         end else if (hdr_pos == ipv4_fwd_pkg::WORD_CSUM) begin
            hdr_csum = word;
            w = '0;
         end else if (hdr_pos == ipv4_fwd_pkg::WORD_DST_HI) begin
            hdr_dest[31:16] = word;
         end else if (hdr_pos == ipv4_fwd_pkg::WORD_DST_LO) begin
            hdr_dest[15:0] = word;
         end
         s = hdr_sum + w;
         hdr_sum = {16'h0, s[15:0]} + (s >> 16);
         if (hdr_pos < ipv4_fwd_pkg::COUNT_MAX)
            hdr_pos = hdr_pos + 5'd1;

         if (last) begin
            // local check walks valid entries up to the first hole
            is_local = 1'b0;
            stop = 1'b0;
            for (i = 0; i < ENTRIES; i++) begin
               if (!stop) begin
                  if (!route_ok[i])
                     stop = 1'b1;
                  else if (route_gw[i] == hdr_dest) begin
                     is_local = 1'b1;
                     stop = 1'b1;
                  end
               end
            end
            v.zero_ttl = 1'b0;
            v.ttl      = hdr_ttl;
            v.csum     = hdr_csum;
            v.iface    = 8'd0;
            v.dest     = hdr_dest;
            if (is_local) begin
               v.status = ipv4_fwd_pkg::STATUS_LOCAL;
            end else begin
               if (hdr_ttl == 8'd0) begin
                  v.zero_ttl = 1'b1;
               end else begin
                  v.ttl = hdr_ttl - 8'd1;
                  s = {16'h0, hdr_sum[15:0]} + (hdr_sum >> 16);
                  v.csum = ~s[15:0] & ipv4_fwd_pkg::ONES_MASK;
               end
               v.status = ipv4_fwd_pkg::STATUS_NO_ROUTE;
               stop = 1'b0;
               for (i = 0; i < ENTRIES; i++) begin
                  if (!stop) begin
                     if (!route_ok[i])
                        stop = 1'b1;
                     else if ((hdr_dest & route_msk[i]) == route_net[i]) begin
                        v.status = ipv4_fwd_pkg::STATUS_FORWARD;
                        v.iface  = route_id[i];
                        stop = 1'b1;
                     end
                  end
               end
            end
            pending_verdicts.push_back(v);
            hdr_pos  = '0;
            hdr_sum  = '0;
            hdr_ttl  = '0;
            hdr_dest = '0;
            hdr_csum = '0;
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Driver: one transfer on the request channel
   // ------------------------------------------------------------------
   task automatic send_item(input logic op, input logic [3:0] idx, input logic [31:0] addr,
                            input logic [31:0] mask, input logic [7:0] id,
                            input logic [15:0] word, input logic last);
      int n;
      if (!quiet && $urandom_range(99) < gap_pct) begin
         n = $urandom_range(10, 1);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_op          <= op;
      req_entry_index <= idx;
      req_iface_addr  <= addr;
      req_iface_mask  <= mask;
      req_iface_id    <= id;
      req_header_word <= word;
      req_last_word   <= last;
      do
         @(posedge clock);
      while (req_stall);
      forward_model_step(op, idx, addr, mask, id, word, last);
      sent++;
   endtask

   task automatic write_route(input logic [3:0] idx, input logic [31:0] addr,
                              input logic [31:0] mask, input logic [7:0] id);
      send_item(ipv4_fwd_pkg::OP_ROUTE_WRITE, idx, addr, mask, id, 16'($urandom),
                1'($urandom));
   endtask

   task automatic send_header_word(input logic [15:0] word, input logic last);
      send_item(ipv4_fwd_pkg::OP_HEADER_WORD, 4'($urandom), $urandom, $urandom,
                8'($urandom), word, last);
   endtask

   task automatic send_packet(input int n_words, input logic [31:0] dest,
                              input logic [7:0] ttl, input fill_kind_type fill);
      logic [15:0] w;
      int          k;
      for (k = 0; k < n_words; k++) begin
         case (fill)
            FILL_ZERO: w = 16'h0000;
            FILL_ONES: w = 16'hffff;
            default:   w = 16'($urandom);
         endcase
         if (k == 0 && fill == FILL_RANDOM)
            w[15:8] = {4'h4, 4'(n_words > 15 ? 15 : n_words / 2)};
         else if (k == ipv4_fwd_pkg::WORD_TTL)
            w[15:8] = ttl;
         else if (k == ipv4_fwd_pkg::WORD_DST_HI)
            w = dest[31:16];
         else if (k == ipv4_fwd_pkg::WORD_DST_LO)
            w = dest[15:0];
         send_header_word(w, k == n_words - 1);
      end
   endtask

   // ------------------------------------------------------------------
   // Random field helpers
   // ------------------------------------------------------------------
   function automatic logic [31:0] pick_mask();
      int p;
      case ($urandom_range(9))
         0:       return 32'h0000_0000;
         1:       return 32'hffff_ffff;
         2:       return $urandom;
         default: begin
            p = $urandom_range(31, 8);
            return 32'hffff_ffff << (32 - p);
         end
      endcase
   endfunction

   function automatic logic [31:0] pick_dest();
      int i;
      i = $urandom_range(ENTRIES - 1);
      case ($urandom_range(9))
         0, 1:    return route_gw[i];
         2, 3, 4, 5: return route_net[i] | ($urandom & ~route_msk[i]);
         6:       return $urandom_range(1) ? 32'hffff_ffff : 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [7:0] pick_ttl();
      case ($urandom_range(7))
         0:       return 8'd0;
         1:       return 8'd1;
         2:       return 8'hff;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic random_route_write();
      write_route(4'($urandom_range(15)), $urandom, pick_mask(), 8'($urandom));
   endtask

   // route writes, mostly well-formed packets, some broken streams and stray words
   task automatic random_traffic(input int goal, input int write_pct, input int odd_pct);
      int r;
      int n;
      while (sent < goal) begin
         r = $urandom_range(99);
         if (r < write_pct) begin
            random_route_write();
         end else if (r < write_pct + odd_pct) begin
            n = $urandom_range(3) == 0 ? $urandom_range(40, 30) : $urandom_range(9, 1);
            send_packet(n, pick_dest(), pick_ttl(), FILL_RANDOM);
         end else if (r < write_pct + odd_pct + 5) begin
            send_header_word(16'($urandom), $urandom_range(3) == 0);
         end else begin
            n = $urandom_range(3) == 0 ? $urandom_range(15, 11) : 10;
            send_packet(n, pick_dest(), pick_ttl(), FILL_RANDOM);
         end
      end
   endtask

   // the last transfer is already taken, so the request channel goes idle first
   task automatic wait_all_verdicts();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0)
         @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_directed();
      gap_pct   = 0;
      stall_pct = 0;
      write_route(4'd0, 32'h0a01_0203, 32'hffff_ff00, 8'ha5);
      // entry beyond a hole is never reached by either walk
      write_route(4'd15, 32'hffff_ffff, 32'hffff_ffff, 8'hff);
      // local wins over a zero TTL
      send_packet(10, 32'h0a01_0203, 8'd0, FILL_ZERO);
      send_packet(10, 32'h0a01_02c8, 8'hff, FILL_ONES);
      // single-word header: TTL and destination never captured
      send_packet(1, 32'h0, 8'h0, FILL_ONES);
      send_packet(10, 32'hffff_ffff, 8'd1, FILL_RANDOM);
   endtask

   task automatic test_sparse_table();
      gap_pct   = 20;
      stall_pct = 20;
      random_traffic(300, 4, 5);
   endtask

   task automatic test_mixed_traffic();
      gap_pct   = 30;
      stall_pct = 30;
      random_traffic(700, 10, 10);
   endtask

   task automatic test_drain_pause();
      int k;
      for (k = 0; k < 3; k++) begin
         send_packet(10, pick_dest(), pick_ttl(), FILL_RANDOM);
         wait_all_verdicts();
      end
   endtask

   task automatic test_odd_lengths();
      gap_pct   = 10;
      stall_pct = 50;
      random_traffic(880, 5, 60);
   endtask

   task automatic test_streaming();
      quiet = 1'b1;
      random_traffic(950, 8, 10);
   endtask

   // ------------------------------------------------------------------
   // Receiver backpressure
   // ------------------------------------------------------------------
   initial begin : rsp_backpressure
      int n;
      forever begin
         @(negedge clock);
         if (!quiet && !reset && $urandom_range(99) < stall_pct) begin
            n = $urandom_range(10, 1);
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Result checker
   // ------------------------------------------------------------------
   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] got_v);
      if (exp_v !== got_v) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual status %0d dest %h",
                     $time, rsp_status, rsp_dest_addr);
            errors++;
         end else begin
            want = pending_verdicts.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("ttl_was_zero", 32'(want.zero_ttl), 32'(rsp_ttl_was_zero));
            check_field("new_ttl", 32'(want.ttl), 32'(rsp_new_ttl));
            check_field("new_checksum", 32'(want.csum), 32'(rsp_new_checksum));
            check_field("out_iface", 32'(want.iface), 32'(rsp_out_iface));
            check_field("dest_addr", want.dest, rsp_dest_addr);
         end
      end
   end

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      for (int i = 0; i < ENTRIES; i++) begin
         route_ok[i]  = 1'b0;
         route_gw[i]  = '0;
         route_msk[i] = '0;
         route_net[i] = '0;
         route_id[i]  = '0;
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_sparse_table();
      test_mixed_traffic();
      test_drain_pause();
      test_odd_lengths();
      test_streaming();

      @(negedge clock);
      req_valid <= 1'b0;
      wait_all_verdicts();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
